// File: rtl/tpa_pkg.sv
// tpa_pkg: shared widths, constants, register indexes and word types
// for the trace pointwise averager; no dependencies
package tpa_pkg;

   // default sizing of the top level
   localparam int TPA_MAX_POINTS  = 4096;
   localparam int TPA_SAMPLE_BITS = 16;

   // fixed field widths
   localparam int NT_W       = 16;
   localparam int NP_W       = 13;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int IDX_W      = 12;
   localparam int MEAN_W     = 24;
   localparam int SUM_W      = 32;
   localparam int MAG_W      = 32;
   localparam int FRAC_W     = 8;

   // quotient bits below the saturation point, and the divider layout
   localparam int QUOT_W     = MAG_W + FRAC_W - NT_W;
   localparam int DIV_STAGES = 8;
   localparam int DIV_STEPS  = QUOT_W / DIV_STAGES;

   // saturation limits of the signed Q8 mean
   localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
   localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_TRACES = 1'b0,
      CSR_NUM_POINTS = 1'b1
   } csr_index_type;

   // one averaging job handed to the divider
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [IDX_W-1:0] point;
      logic             last;
   } tpa_job_type;

   // divider result: quotient with overflow and sign
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
      logic [IDX_W-1:0]  point;
      logic              last;
   } tpa_quot_type;

endpackage

// File: rtl/tpa_div.sv
// tpa_div: pipelined restoring divider for the scaled magnitude of a point sum
// depends on tpa_pkg
module tpa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [tpa_pkg::NT_W-1:0] divisor,
   input  logic                 in_valid,
   input  tpa_pkg::tpa_job_type in_job,
   output logic                 in_stall,
   output logic                 out_valid,
   output tpa_pkg::tpa_quot_type out_word,
   input  logic                 out_stall
);
   import tpa_pkg::*;

   typedef struct packed {
      logic [NT_W-1:0]   rem;
      logic [QUOT_W-1:0] word;
   } div_state_type;

   // several restoring steps; quotient bits shift in from the bottom
   function automatic div_state_type div_steps(div_state_type st, logic [NT_W-1:0] dvs);
      div_state_type cur;
      logic [NT_W:0] trial;
      logic [NT_W:0] diff;
      cur = st;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {cur.rem, cur.word[QUOT_W-1]};
         diff  = trial - {1'b0, dvs};
         if (trial >= {1'b0, dvs}) begin
            cur.rem  = diff[NT_W-1:0];
            cur.word = {cur.word[QUOT_W-2:0], 1'b1};
         end else begin
            cur.rem  = trial[NT_W-1:0];
            cur.word = {cur.word[QUOT_W-2:0], 1'b0};
         end
      end
      return cur;
   endfunction

   logic          v_ff    [DIV_STAGES];
   div_state_type st_ff   [DIV_STAGES];
   logic          neg_ff  [DIV_STAGES];
   logic          ovf_ff  [DIV_STAGES];
   logic [IDX_W-1:0] pt_ff [DIV_STAGES];
   logic          last_ff [DIV_STAGES];
   logic [DIV_STAGES:0] rdy;
   div_state_type st_first;
   logic          ovf_first;

   // first stage: split the dividend and flag quotients past the saturation point
   always_comb begin
      st_first.rem  = in_job.mag[MAG_W-1 -: NT_W];
      st_first.word = {in_job.mag[MAG_W-NT_W-1:0], {FRAC_W{1'b0}}};
      ovf_first     = in_job.mag >= {divisor, {(MAG_W-NT_W){1'b0}}};
   end

   // stage ready chain, bubbles collapse
   assign rdy[DIV_STAGES] = !out_stall;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic          vin;
      div_state_type sin;
      logic          nin;
      logic          oin;
      logic [IDX_W-1:0] pin;
      logic          lin;

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      if (k == 0) begin : g_head
         assign vin = in_valid;
         assign sin = st_first;
         assign nin = in_job.neg;
         assign oin = ovf_first;
         assign pin = in_job.point;
         assign lin = in_job.last;
      end else begin : g_body
         assign vin = v_ff[k-1];
         assign sin = st_ff[k-1];
         assign nin = neg_ff[k-1];
         assign oin = ovf_ff[k-1];
         assign pin = pt_ff[k-1];
         assign lin = last_ff[k-1];
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= vin;
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (rdy[k] && vin) begin
            st_ff[k]   <= div_steps(sin, divisor);
            neg_ff[k]  <= nin;
            ovf_ff[k]  <= oin;
            pt_ff[k]   <= pin;
            last_ff[k] <= lin;
         end
      end
   end

   assign in_stall       = !rdy[0];
   assign out_valid      = v_ff[DIV_STAGES-1];
   assign out_word.neg   = neg_ff[DIV_STAGES-1];
   assign out_word.ovf   = ovf_ff[DIV_STAGES-1];
   assign out_word.quot  = st_ff[DIV_STAGES-1].word;
   assign out_word.point = pt_ff[DIV_STAGES-1];
   assign out_word.last  = last_ff[DIV_STAGES-1];

endmodule

// File: rtl/trace_pointwise_averager.sv
// trace_pointwise_averager: coherent averaging of sample traces, one sum per point
// depends on tpa_pkg and tpa_div
//
// usage
// - req_ carries one signed sample per word; samples come trace by trace, every
//   point of a trace in order, and each is added into the sum of its point
// - on a sample of the final trace, rsp_ returns one word: the Q8 mean of that
//   point, (sum + sample) * 256 / num_traces truncated toward zero and saturated
//   to 24 bits, with the point index and a flag on the last point of the run;
//   earlier traces give no word; the final trace restarts the point's sum at zero
// - csr_ writes num_traces (index 0) and num_points (index 1) while idle
// - throughput is one sample per cycle unless stalled; the sum memory is read at
//   accept, written back on advance, with forwarding when the same point follows
// - from accept to rsp_valid a sample passes the read-modify-write stage, the
//   eight divider stages (three quotient bits per stage) and the output register
// - after reset the block sweeps all MAX_POINTS entries of the sum memory to zero,
//   one entry a cycle, with req_stall high; register writes are taken meanwhile
// - a stalled result waits in the output register; further samples are taken
//   until the divider stages fill up, then a final-trace sample stalls the input
module trace_pointwise_averager #(
   parameter int MAX_POINTS  = tpa_pkg::TPA_MAX_POINTS,
   parameter int SAMPLE_BITS = tpa_pkg::TPA_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpa_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tpa_pkg::MEAN_W-1:0]   rsp_mean_value,
   output logic [tpa_pkg::IDX_W-1:0]           rsp_point_index,
   output logic                                rsp_last_point
);
   import tpa_pkg::*;

   localparam int PT_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LIM_W = PT_W + 1;
   localparam int CMP_W = (LIM_W > NP_W) ? LIM_W : NP_W;
   localparam int TOT_W = SUM_W + 1;

   logic [NT_W-1:0]  csr_num_traces_ff;
   logic [NP_W-1:0]  csr_num_points_ff;
   logic [NT_W-1:0]  nt_eff;
   logic [CMP_W-1:0] np_ext;
   logic [CMP_W-1:0] np_max;
   logic [CMP_W-1:0] np_eff;

   logic             clr_busy_ff;
   logic [PT_W-1:0]  clr_addr_ff;

   logic [PT_W-1:0]  pt_ff;
   logic [NT_W-1:0]  tr_ff;
   logic             last_pt;
   logic             final_tr;
   logic             req_acc;

   logic             s1_valid_ff;
   logic [PT_W-1:0]  s1_addr_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic             s1_final_ff;
   logic             s1_last_ff;
   logic             s1_adv;

   logic [SUM_W-1:0] sum_mem [MAX_POINTS];
   logic [SUM_W-1:0] rdata_ff;
   logic             fwd_ff;
   logic [SUM_W-1:0] fwd_data_ff;

   logic signed [SUM_W-1:0] base;
   logic signed [TOT_W-1:0] total;
   logic [TOT_W-1:0] mag_full;
   logic             tot_neg;
   logic [SUM_W-1:0] s1_wdata;

   logic             mem_we;
   logic [PT_W-1:0]  mem_waddr;
   logic [SUM_W-1:0] mem_wdata;

   tpa_job_type      div_job;
   logic             div_in_valid;
   logic             div_stall;
   logic             div_out_valid;
   tpa_quot_type     div_out;
   logic             div_out_stall;

   logic             out_rdy;
   logic [MEAN_W-1:0] mean_sat;
   logic             rsp_valid_ff;
   logic [MEAN_W-1:0] rsp_mean_ff;
   logic [IDX_W-1:0] rsp_point_ff;
   logic             rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_num_traces_ff <= NT_W'(1);
         csr_num_points_ff <= NP_W'(TPA_MAX_POINTS);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_TRACES: csr_num_traces_ff <= csr_wr_data[NT_W-1:0];
            CSR_NUM_POINTS: csr_num_points_ff <= csr_wr_data[NP_W-1:0];
            default: ;
         endcase
      end
   end

   // effective limits: zero acts as one, points capped at the memory depth
   always_comb begin
      nt_eff = (csr_num_traces_ff == '0) ? NT_W'(1) : csr_num_traces_ff;
      np_ext = CMP_W'(csr_num_points_ff);
      np_max = CMP_W'(MAX_POINTS);
      if (np_ext == '0) begin
         np_eff = CMP_W'(1);
      end else if (np_ext > np_max) begin
         np_eff = np_max;
      end else begin
         np_eff = np_ext;
      end
   end

   // position of the incoming sample in the run
   assign last_pt  = (CMP_W'(pt_ff) + CMP_W'(1)) >= np_eff;
   assign final_tr = ({1'b0, tr_ff} + (NT_W+1)'(1)) >= {1'b0, nt_eff};

   // front handshake
   assign s1_adv    = !s1_valid_ff || !s1_final_ff || !div_stall;
   assign req_stall = clr_busy_ff || !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == PT_W'(MAX_POINTS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + PT_W'(1);
      end
   end

   // point and trace counters
   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff <= '0;
         tr_ff <= '0;
      end else if (req_acc) begin
         if (last_pt) begin
            pt_ff <= '0;
            tr_ff <= final_tr ? '0 : tr_ff + NT_W'(1);
         end else begin
            pt_ff <= pt_ff + PT_W'(1);
         end
      end
   end

   // read-modify-write stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= req_acc;
         end
         if (req_acc) begin
            fwd_ff <= s1_valid_ff && (s1_addr_ff == pt_ff);
         end
      end
   end

   // read-modify-write stage payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_addr_ff   <= pt_ff;
         s1_sample_ff <= req_sample;
         s1_final_ff  <= final_tr;
         s1_last_ff   <= last_pt;
         fwd_data_ff  <= s1_wdata;
      end
   end

   // sum memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      if (req_acc) begin
         rdata_ff <= sum_mem[pt_ff];
      end
   end

   // add the sample, forwarding the write of the item just ahead
   always_comb begin
      base     = fwd_ff ? fwd_data_ff : rdata_ff;
      total    = TOT_W'(base) + TOT_W'(s1_sample_ff);
      tot_neg  = total[TOT_W-1];
      mag_full = tot_neg ? TOT_W'(0) - total : total;
      s1_wdata = s1_final_ff ? '0 : total[SUM_W-1:0];
   end

   // write port shared by the clearing sweep and the stage
   assign mem_we    = clr_busy_ff || (s1_valid_ff && s1_adv);
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : s1_wdata;

   // final-trace samples go on to the divider
   assign div_in_valid  = s1_valid_ff && s1_final_ff;
   assign div_job.neg   = tot_neg;
   assign div_job.mag   = mag_full[MAG_W-1:0];
   assign div_job.point = IDX_W'(s1_addr_ff);
   assign div_job.last  = s1_last_ff;

   tpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .divisor   (nt_eff),
      .in_valid  (div_in_valid),
      .in_job    (div_job),
      .in_stall  (div_stall),
      .out_valid (div_out_valid),
      .out_word  (div_out),
      .out_stall (div_out_stall)
   );

   // signed saturation of the quotient
   always_comb begin
      if (div_out.neg) begin
         if (div_out.ovf || (div_out.quot > QUOT_W'(MEAN_MIN))) begin
            mean_sat = MEAN_MIN;
         end else begin
            mean_sat = MEAN_W'(QUOT_W'(0) - div_out.quot);
         end
      end else begin
         if (div_out.ovf || (div_out.quot > QUOT_W'(MEAN_MAX))) begin
            mean_sat = MEAN_MAX;
         end else begin
            mean_sat = MEAN_W'(div_out.quot);
         end
      end
   end

   // output register
   assign out_rdy       = !rsp_valid_ff || !rsp_stall;
   assign div_out_stall = !out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && div_out_valid) begin
         rsp_mean_ff  <= mean_sat;
         rsp_point_ff <= div_out.point;
         rsp_last_ff  <= div_out.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_point_index = rsp_point_ff;
   assign rsp_last_point  = rsp_last_ff;

   // clearing sweep runs once after reset
   a_clr_once: assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> !clr_busy_ff)
      else $error("clearing sweep restarted");

   // nothing is in flight while the sweep owns the write port
   a_clr_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("item in flight during clearing sweep");

   // the last point of a trace wraps the point counter
   a_pt_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_pt) |=> (pt_ff == '0))
      else $error("point counter did not wrap");

   // the last point of the final trace restarts the run
   a_tr_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_pt && final_tr) |=> (tr_ff == '0))
      else $error("trace counter did not restart");

endmodule

// File: test/trace_pointwise_averager_tb.sv
// trace_pointwise_averager_tb: self-checking bench for the trace pointwise averager
// predicts every mean word from its own model of the per-point sums and counters
// depends on tpa_pkg and the trace_pointwise_averager rtl
`timescale 1ns / 100ps

module trace_pointwise_averager_tb;
   import tpa_pkg::*;

   localparam int NUM_SLOTS     = 4096;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int QUIET_FROM    = 1450;
   localparam int HOLD_OFF      = 400;
   localparam int CYCLE_LIMIT   = 600000;

   // one expected mean word
   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [IDX_W-1:0]  point;
      logic              last;
   } mean_word_type;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} drill_kind_type;

   // one row of the directed drill
   typedef struct {
      drill_kind_type    kind;
      csr_index_type     reg_idx;
      logic [15:0]       wr_data;
      logic signed [15:0] sample;
      bit                typed;
      mean_word_type     word;
   } drill_row_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [15:0]       req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [MEAN_W-1:0] rsp_mean_value;
   logic [IDX_W-1:0]         rsp_point_index;
   logic                     rsp_last_point;

   // predictor state
   logic [31:0] point_acc [NUM_SLOTS];
   logic [11:0] point_pos;
   logic [15:0] trace_pos;
   logic [15:0] cfg_traces;
   logic [12:0] cfg_points;

   mean_word_type pending_means[$];
   drill_row_type drill[$];
   int          error_count = 0;
   int          samples_sent = 0;
   int          cycle_count = 0;
   int          tx_gap_pct = 0;
   int          rx_stall_pct = 0;
   int          hold_cycles = 0;

   trace_pointwise_averager u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_point_index (rsp_point_index),
      .rsp_last_point  (rsp_last_point)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("trace_pointwise_averager_tb failed");
         $finish;
      end
   end

   // mean of one point: accumulate, and on the final trace divide, saturate, clear
   function automatic void predict_mean(input logic signed [15:0] s,
                                        output bit has_word, output mean_word_type w);
      longint            nt;
      longint            np;
      longint            total;
      longint            mag;
      longint            q;
      logic signed [31:0] acc;
      bit                last_pt;
      bit                final_tr;
      nt = (cfg_traces == 0) ? 1 : cfg_traces;
      np = (cfg_points == 0) ? 1 : cfg_points;
      if (np > NUM_SLOTS)
         np = NUM_SLOTS;
      acc = point_acc[point_pos];
      total = acc + s;
      last_pt = (longint'(point_pos) + 1 >= np);
      final_tr = (longint'(trace_pos) + 1 >= nt);
      has_word = final_tr;
      w = '0;
      if (final_tr) begin
         mag = (total < 0) ? -total : total;
         mag = (mag << 8) / nt;
         if (total < 0)
            q = (mag > 8388608) ? -8388608 : -mag;
         else
            q = (mag > 8388607) ? 8388607 : mag;
         w.mean = q[MEAN_W-1:0];
         w.point = point_pos;
         w.last = last_pt;
         point_acc[point_pos] = '0;
      end else begin
         point_acc[point_pos] = total[31:0];
      end
      // a position at or past the limit counts as the last one
      if (last_pt) begin
         point_pos = '0;
         trace_pos = final_tr ? 16'd0 : trace_pos + 16'd1;
      end else begin
         point_pos = point_pos + 12'd1;
      end
   endfunction

   function automatic drill_row_type row_sample(input logic signed [15:0] s);
      drill_row_type r;
      r = '{ROW_SAMPLE, CSR_NUM_TRACES, 16'd0, s, 1'b0, '0};
      return r;
   endfunction

   function automatic drill_row_type row_check(input logic signed [15:0] s,
                                               input logic [23:0] mean,
                                               input logic [11:0] point, input logic last);
      drill_row_type r;
      r = '{ROW_SAMPLE, CSR_NUM_TRACES, 16'd0, s, 1'b1, '{mean, point, last}};
      return r;
   endfunction

   function automatic drill_row_type row_write(input csr_index_type idx,
                                               input logic [15:0] data);
      drill_row_type r;
      r = '{ROW_WRITE, idx, data, 16'sd0, 1'b0, '0};
      return r;
   endfunction

   // register write, taken at the next rising edge
   task automatic csr_write(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      if (idx == CSR_NUM_TRACES)
         cfg_traces = data;
      else
         cfg_points = data[12:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // offer one sample word, then log its expected mean once accepted
   task automatic send_sample(input logic signed [15:0] s, input bit typed,
                              input mean_word_type typed_word);
      bit            has_word;
      mean_word_type w;
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= s;
      do
         @(posedge clock);
      while (req_stall);
      predict_mean(s, has_word, w);
      if (has_word)
         pending_means.push_back(typed ? typed_word : w);
      samples_sent++;
   endtask

   // random sender gap before a sample
   task automatic maybe_gap();
      int n;
      if ($urandom_range(0, 99) < tx_gap_pct) begin
         n = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait until every expected mean has come out
   task automatic settle_block(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_means.size() != 0)
         @(negedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // receiver: stall bursts, plus a long hold-off on request
   initial begin
      int burst_left;
      burst_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rsp_stall <= 1'b1;
            burst_left = $urandom_range(0, 17);
         end else begin
            rsp_stall <= 1'b0;
            burst_left = $urandom_range(0, 24);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      mean_word_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_means.size() == 0) begin
            $error("unexpected mean word: mean %0d point %0d last %0d",
                   rsp_mean_value, rsp_point_index, rsp_last_point);
            error_count++;
         end else begin
            exp_word = pending_means.pop_front();
            if (rsp_mean_value !== exp_word.mean) begin
               $error("mean_value: expected %0d, actual %0d",
                      $signed(exp_word.mean), rsp_mean_value);
               error_count++;
            end
            if (rsp_point_index !== exp_word.point) begin
               $error("point_index: expected %0d, actual %0d",
                      exp_word.point, rsp_point_index);
               error_count++;
            end
            if (rsp_last_point !== exp_word.last) begin
               $error("last_point: expected %0d, actual %0d",
                      exp_word.last, rsp_last_point);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int                 phase;
      int                 len;
      int                 sel;
      int                 smode;
      logic [15:0]        nt_data;
      logic [15:0]        np_data;
      logic signed [15:0] s;
      int                 eff_traces;

      // predictor reset
      foreach (point_acc[i])
         point_acc[i] = '0;
      point_pos = '0;
      trace_pos = '0;
      cfg_traces = 16'd1;
      cfg_points = 13'd4096;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset values: every sample is its own mean
      drill.push_back(row_check(16'sh7FFF, 24'h7FFF00, 12'd0, 1'b0));
      drill.push_back(row_check(-16'sd32768, 24'h800000, 12'd1, 1'b0));
      drill.push_back(row_check(16'sd0, 24'h000000, 12'd2, 1'b0));
      drill.push_back(row_check(-16'sd1, 24'hFFFF00, 12'd3, 1'b0));
      // zero trace count acts as one; point counter already past the new limit
      drill.push_back(row_write(CSR_NUM_TRACES, 16'd0));
      drill.push_back(row_write(CSR_NUM_POINTS, 16'd3));
      drill.push_back(row_check(16'sd5, 24'h000500, 12'd4, 1'b1));
      drill.push_back(row_check(16'sd7, 24'h000700, 12'd0, 1'b0));
      // zero point count acts as one
      drill.push_back(row_write(CSR_NUM_POINTS, 16'd0));
      drill.push_back(row_check(-16'sd3, 24'hFFFD00, 12'd1, 1'b1));
      // positive saturation: trace count lowered to the trace counter
      drill.push_back(row_write(CSR_NUM_TRACES, 16'd3));
      drill.push_back(row_sample(16'sh7FFF));
      drill.push_back(row_sample(16'sh7FFF));
      drill.push_back(row_write(CSR_NUM_TRACES, 16'd2));
      drill.push_back(row_check(16'sh7FFF, 24'h7FFFFF, 12'd0, 1'b1));
      // negative saturation
      drill.push_back(row_write(CSR_NUM_TRACES, 16'd3));
      drill.push_back(row_sample(-16'sd32768));
      drill.push_back(row_sample(-16'sd32768));
      drill.push_back(row_write(CSR_NUM_TRACES, 16'd2));
      drill.push_back(row_check(-16'sd32768, 24'h800000, 12'd0, 1'b1));
      // truncation toward zero on both signs
      drill.push_back(row_write(CSR_NUM_TRACES, 16'd3));
      drill.push_back(row_write(CSR_NUM_POINTS, 16'd2));
      drill.push_back(row_sample(16'sd1));
      drill.push_back(row_sample(-16'sd1));
      drill.push_back(row_sample(16'sd0));
      drill.push_back(row_sample(16'sd0));
      drill.push_back(row_sample(16'sd0));
      drill.push_back(row_sample(16'sd0));
      // largest trace count, point count above the maximum
      drill.push_back(row_write(CSR_NUM_POINTS, 16'hFFFF));
      drill.push_back(row_write(CSR_NUM_TRACES, 16'hFFFF));
      drill.push_back(row_sample(16'sd12345));
      drill.push_back(row_sample(-16'sd12345));

      tx_gap_pct = 20;
      rx_stall_pct = 20;
      foreach (drill[i]) begin
         if (drill[i].kind == ROW_WRITE) begin
            settle_block(SETTLE_CYCLES);
            csr_write(drill[i].reg_idx, drill[i].wr_data);
         end else begin
            maybe_gap();
            send_sample(drill[i].sample, drill[i].typed, drill[i].word);
         end
      end

      // random phases, each starting from an idle block
      phase = 0;
      while (samples_sent < RANDOM_ITEMS) begin
         settle_block(SETTLE_CYCLES);
         sel = (phase == 0) ? -1 : int'($urandom_range(0, 7));
         case (sel)
            -1: begin
               nt_data = 16'd1;
               np_data = 16'd64;
            end
            0: begin
               nt_data = 16'd1;
               np_data = 16'($urandom_range(1, 4096));
            end
            1: begin
               nt_data = 16'hFFFF;
               np_data = 16'($urandom_range(1, 3));
            end
            2: begin
               nt_data = 16'd0;
               np_data = 16'd0;
            end
            3: begin
               nt_data = 16'($urandom_range(1, 5));
               np_data = 16'd4096;
            end
            4: begin
               nt_data = 16'($urandom_range(1, 4));
               np_data = 16'($urandom());
            end
            5: begin
               nt_data = 16'($urandom());
               np_data = 16'($urandom_range(1, 4));
            end
            default: begin
               nt_data = 16'($urandom_range(1, 6));
               np_data = 16'($urandom_range(1, 12));
            end
         endcase
         // sometimes only one register moves, leaving counters past the new limit
         case ((phase == 0) ? 3 : $urandom_range(0, 3))
            0: csr_write(CSR_NUM_TRACES, nt_data);
            1: csr_write(CSR_NUM_POINTS, np_data);
            default: begin
               csr_write(CSR_NUM_TRACES, nt_data);
               csr_write(CSR_NUM_POINTS, np_data);
            end
         endcase

         eff_traces = (cfg_traces == 0) ? 1 : cfg_traces;
         len = (eff_traces > 8) ? 12 : $urandom_range(20, 100);
         smode = $urandom_range(0, 3);
         if (samples_sent >= QUIET_FROM) begin
            tx_gap_pct = 0;
            rx_stall_pct = 0;
         end else begin
            tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
         end
         // first phase: receiver holds off while samples keep coming
         if (phase == 0) begin
            len = 100;
            tx_gap_pct = 0;
            hold_cycles = HOLD_OFF;
         end

         for (int k = 0; k < len; k++) begin
            // in the third phase the sender pauses mid-phase until every mean is out
            if (phase == 2 && k == len / 2)
               settle_block(0);
            case (smode)
               1: s = $signed(16'($urandom_range(0, 16))) - 16'sd8;
               2: s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               default: s = 16'($urandom());
            endcase
            maybe_gap();
            send_sample(s, 1'b0, '0);
         end
         phase++;
      end

      // drain and finish
      settle_block(20);
      if (error_count == 0)
         $display("trace_pointwise_averager_tb passed");
      else
         $display("trace_pointwise_averager_tb failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tpa_pkg.sv
rtl/tpa_div.sv
rtl/trace_pointwise_averager.sv
test/trace_pointwise_averager_tb.sv
